### hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants for the minimum priority queue
// Item formats, codes, controller states, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] min_value;
        logic                      is_empty;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic issue_read;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic op_dequeue;
        logic store_empty;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl: sequencing state machine
// Accepts one item, steps the datapath through the scan for a dequeue on a non-empty store, and commits.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mpq_pkg::dp_status_t status,
    output mpq_pkg::ctl_cmd_t   cmd
);

    import mpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.op_dequeue && !status.store_empty)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.issue_read = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_SCAN:
            begin
                cmd.issue_read = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    // The scan is only entered for a dequeue on a non-empty store.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (status.op_dequeue && !status.store_empty))
        else $error("scan running on an empty store or for an enqueue");

endmodule

### hw/rtl/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp: queue datapath
// Entry memory, count, one-compare-per-cycle minimum scan, and result register.
// ----------------------------------------------------------------------------
module mpq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpq_pkg::in_item_t   in_item,
    input  mpq_pkg::ctl_cmd_t   cmd,
    output mpq_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output mpq_pkg::out_item_t  out_item
);

    import mpq_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [AW-1:0]             scan_idx_reg;
    logic                      rd_pend_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [AW-1:0]             best_idx_reg;
    logic signed [VALUE_W-1:0] last_val_reg;
    logic                      out_valid_reg;
    out_item_t                 out_item_reg;
    out_item_t                 out_item_next;

    logic [CNT_W-1:0]          count_m1;
    logic [AW-1:0]             last_idx;
    logic                      store_full;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] rd_val;

    assign count_m1   = count_reg - CNT_W'(1);
    assign last_idx   = count_m1[AW-1:0];
    assign store_full = (count_reg == CNT_W'(CAPACITY));
    assign rd_val     = $signed(ram_rdata);

    assign status.op_dequeue  = (op_reg == OP_DEQUEUE);
    assign status.store_empty = (count_reg == '0);
    assign status.scan_last   = (scan_idx_reg == last_idx);
    assign status.out_free    = !out_valid_reg || out_ready;

    mpq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue_read),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = best_idx_reg;
        ram_wdata     = last_val_reg;
        count_next    = count_reg;
        out_item_next = '0;
        if (op_reg == OP_ENQUEUE)
        begin
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = value_reg;
            if (store_full)
            begin
                out_item_next.status = STATUS_FULL;
            end
            else
            begin
                ram_we     = cmd.commit;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (count_reg == '0)
        begin
            out_item_next.status = STATUS_EMPTY;
        end
        else
        begin
            ram_we                  = cmd.commit;
            count_next              = count_m1;
            out_item_next.min_value = best_val_reg;
        end
        out_item_next.is_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue_read;
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg       <= in_item.opcode;
            value_reg    <= in_item.value;
            scan_idx_reg <= '0;
        end
        else if (cmd.issue_read)
        begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
        rd_idx_reg <= scan_idx_reg;
        if (rd_pend_reg)
        begin
            if ((rd_idx_reg == '0) || (rd_val < best_val_reg))
            begin
                best_val_reg <= rd_val;
                best_idx_reg <= rd_idx_reg;
            end
            if (rd_idx_reg == last_idx)
            begin
                last_val_reg <= rd_val;
            end
        end
        if (cmd.commit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit would overwrite an untaken result");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_ENQUEUE) && !store_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not advance the count");

endmodule

### hw/rtl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue: minimum priority queue with a linear scan
// Stores up to CAPACITY signed values; dequeue returns and removes a smallest.
// ----------------------------------------------------------------------------
// An enqueue passes through dispatch and finish back to idle; a dequeue on a
// non-empty store also passes through scan and drain, because the scan reads
// one entry per cycle through the single read port of the entry memory and
// compares it against the running minimum. The result waits in an output
// register, and the next item is accepted while it waits; an item only stalls
// at its end if the previous result has still not been taken. Enqueue into a
// full store returns status full, dequeue from an empty store status empty.
module min_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mpq_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mpq_pkg::out_item_t out_item
);

    import mpq_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    mpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
